// ===== design/dnpc_pkg.sv =====
`timescale 1ns / 1ps

package dnpc_pkg;

    // Default sizes
    localparam int PADS_MAX_DEF  = 1024;
    localparam int NEIGHBORS_DEF = 3;

    // Number of neighbor indices on the result channel
    localparam int REPORTED = 3;

    // Field widths
    localparam int KIND_W   = 2;
    localparam int COORD_W  = 32;
    localparam int SIZE_W   = 31;
    localparam int QIDX_W   = 10;
    localparam int QUAD_W   = 2;
    localparam int STATUS_W = 2;
    localparam int SPACE_W  = 31;
    localparam int NCNT_W   = 2;
    localparam int NIDX_W   = 10;

    // Squared distance: two 64-bit squares plus carry
    localparam int DIST_W = 2 * COORD_W + 1;
    // Signed clearance: 32-bit magnitude minus 31-bit half sum
    localparam int GAP_W  = COORD_W + 2;

    localparam logic [SPACE_W-1:0] SPACE_MAX = '1;

    // Item kinds
    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD  = 2'd0,
        KIND_QUERY = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    // Result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOIDX = 2'd2;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_QLAT,
        ST_SCAN,
        ST_DRAIN,
        ST_GRD,
        ST_GABS,
        ST_GDIF,
        ST_GMIN,
        ST_FIN
    } t_state;

    // One stored pad
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [SIZE_W-1:0]         w;
        logic [SIZE_W-1:0]         h;
    } t_pad;

    localparam int PAD_W = $bits(t_pad);

    // Control into the nearest-neighbor keeper
    typedef struct packed {
        logic clear;
        logic insert;
    } t_keep_ctl;

endpackage

// ===== design/dnpc_ram.sv =====
`timescale 1ns / 1ps

module dnpc_ram #(
    parameter int WIDTH = dnpc_pkg::PAD_W,
    parameter int DEPTH = dnpc_pkg::PADS_MAX_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/dnpc_keep.sv =====
`timescale 1ns / 1ps

module dnpc_keep #(
    parameter int NEIGHBORS = dnpc_pkg::NEIGHBORS_DEF,
    parameter int IDX_W     = $clog2(dnpc_pkg::PADS_MAX_DEF)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dnpc_pkg::t_keep_ctl                 i_ctl,
    input  logic [dnpc_pkg::DIST_W-1:0]         i_dist,
    input  logic [IDX_W-1:0]                    i_idx,
    output logic [NEIGHBORS-1:0]                o_valid,
    output logic [NEIGHBORS-1:0][IDX_W-1:0]     o_idx
);

    import dnpc_pkg::*;

    logic [NEIGHBORS-1:0]              r_valid, n_valid;
    logic [NEIGHBORS-1:0][DIST_W-1:0]  r_dist, n_dist;
    logic [NEIGHBORS-1:0][IDX_W-1:0]   r_idx, n_idx;

    logic [NEIGHBORS-1:0]              less;
    logic [NEIGHBORS-1:0]              prev_less;
    logic [NEIGHBORS-1:0]              sh_valid;
    logic [NEIGHBORS-1:0][DIST_W-1:0]  sh_dist;
    logic [NEIGHBORS-1:0][IDX_W-1:0]   sh_idx;

    // Sorted list: candidate lands after every entry at equal or smaller distance
    always_comb begin
        for (int k = 0; k < NEIGHBORS; k++) begin
            less[k] = !r_valid[k] || (i_dist < r_dist[k]);
        end
        prev_less = less << 1;
        sh_valid  = r_valid << 1;
        sh_dist   = r_dist << DIST_W;
        sh_idx    = r_idx << IDX_W;

        n_valid = r_valid;
        n_dist  = r_dist;
        n_idx   = r_idx;
        if (i_ctl.insert) begin
            for (int k = 0; k < NEIGHBORS; k++) begin
                if (less[k] && !prev_less[k]) begin
                    n_valid[k] = 1'b1;
                    n_dist[k]  = i_dist;
                    n_idx[k]   = i_idx;
                end else if (less[k]) begin
                    n_valid[k] = sh_valid[k];
                    n_dist[k]  = sh_dist[k];
                    n_idx[k]   = sh_idx[k];
                end
            end
        end
        if (i_ctl.clear) begin
            n_valid = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist <= n_dist;
        r_idx  <= n_idx;
    end

    assign o_valid = r_valid;
    assign o_idx   = r_idx;

endmodule

// ===== design/directional_nearest_pad_clearance_core.sv =====
`timescale 1ns / 1ps

// Channel  | Handshake                | Payload
// ---------+--------------------------+-------------------------------------------------
// input    | i_in_valid / o_in_ready  | i_kind i_pos_x i_pos_y i_box_width i_box_height
//          |                          | i_query_index i_quadrant
// result   | o_out_valid / i_out_ready| o_status o_available_space o_neighbor_count
//          |                          | o_first_neighbor o_second_neighbor o_third_neighbor
//
// Load, clear and unused kinds are answered straight from the idle state. A query makes
// one table read per stored pad through a single read port, a four-stage distance pipeline
// behind it, then steps the clearance unit through read, magnitude, difference and
// minimum for each kept neighbor.
// Reset clears the pad count and the sequencer; the pad table needs no clearing.
// A result waits in the output register; the block takes a new transfer only when
// the sequencer is idle and that register is empty or being drained.

module directional_nearest_pad_clearance_core #(
    parameter int PADS_MAX  = dnpc_pkg::PADS_MAX_DEF,
    parameter int NEIGHBORS = dnpc_pkg::NEIGHBORS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [dnpc_pkg::KIND_W-1:0]        i_kind,
    input  logic signed [dnpc_pkg::COORD_W-1:0] i_pos_x,
    input  logic signed [dnpc_pkg::COORD_W-1:0] i_pos_y,
    input  logic [dnpc_pkg::SIZE_W-1:0]        i_box_width,
    input  logic [dnpc_pkg::SIZE_W-1:0]        i_box_height,
    input  logic [dnpc_pkg::QIDX_W-1:0]        i_query_index,
    input  logic [dnpc_pkg::QUAD_W-1:0]        i_quadrant,

    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [dnpc_pkg::STATUS_W-1:0]      o_status,
    output logic [dnpc_pkg::SPACE_W-1:0]       o_available_space,
    output logic [dnpc_pkg::NCNT_W-1:0]        o_neighbor_count,
    output logic [dnpc_pkg::NIDX_W-1:0]        o_first_neighbor,
    output logic [dnpc_pkg::NIDX_W-1:0]        o_second_neighbor,
    output logic [dnpc_pkg::NIDX_W-1:0]        o_third_neighbor
);

    import dnpc_pkg::*;

    localparam int IDX_W    = $clog2(PADS_MAX);
    localparam int CNT_W    = $clog2(PADS_MAX + 1);
    localparam int CMP_W    = (CNT_W > QIDX_W) ? CNT_W : QIDX_W;
    localparam int IDXO_W   = (IDX_W > NIDX_W) ? IDX_W : NIDX_W;
    localparam int K_W      = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
    localparam int SCAN_LAT = 4;

    // Difference of two signed coordinates, one bit wider
    function automatic logic [COORD_W:0] f_diff(input logic signed [COORD_W-1:0] a,
                                                input logic signed [COORD_W-1:0] b);
        return {a[COORD_W-1], a} - {b[COORD_W-1], b};
    endfunction

    // Magnitude picked from the two opposite differences
    function automatic logic [COORD_W-1:0] f_mag(input logic [COORD_W:0] d_ab,
                                                 input logic [COORD_W:0] d_ba);
        return d_ab[COORD_W] ? d_ba[COORD_W-1:0] : d_ab[COORD_W-1:0];
    endfunction

    // Sequencer and stored state
    t_state                    r_state, n_state;
    logic [CNT_W-1:0]          r_count, n_count;
    logic [IDX_W-1:0]          r_q, n_q;
    logic [QUAD_W-1:0]         r_quad, n_quad;
    logic signed [COORD_W-1:0] r_ox, n_ox;
    logic signed [COORD_W-1:0] r_oy, n_oy;
    logic [SIZE_W-1:0]         r_ow, n_ow;
    logic [SIZE_W-1:0]         r_oh, n_oh;
    logic [CNT_W-1:0]          r_scan, n_scan;
    logic [1:0]                r_drain, n_drain;
    logic [K_W-1:0]            r_k, n_k;

    // Clearance unit
    logic [COORD_W-1:0]        r_gax, n_gax;
    logic [COORD_W-1:0]        r_gay, n_gay;
    logic [SIZE_W-1:0]         r_hw, n_hw;
    logic [SIZE_W-1:0]         r_hh, n_hh;
    logic signed [GAP_W-1:0]   r_gx, n_gx;
    logic signed [GAP_W-1:0]   r_gy, n_gy;
    logic signed [GAP_W-1:0]   r_space, n_space;
    logic signed [GAP_W-1:0]   gap_min;

    // Result register
    logic                      r_ovalid, n_ovalid;
    logic [STATUS_W-1:0]       r_status, n_status;
    logic [SPACE_W-1:0]        r_ospace, n_ospace;
    logic [NCNT_W-1:0]         r_ncount, n_ncount;
    logic [NIDX_W-1:0]         r_n0, n_n0;
    logic [NIDX_W-1:0]         r_n1, n_n1;
    logic [NIDX_W-1:0]         r_n2, n_n2;

    // Distance pipeline
    logic                      r_v0, r_v1, r_v2, r_v3;
    logic [IDX_W-1:0]          r_p0, r_p1, r_p2, r_p3;
    logic [COORD_W-1:0]        r_ax1, r_ay1;
    logic [2*COORD_W-1:0]      r_sx2, r_sy2;
    logic [DIST_W-1:0]         r_d3;

    // Table port
    logic                      ram_we;
    logic [IDX_W-1:0]          ram_waddr;
    t_pad                      ram_wpad;
    logic [IDX_W-1:0]          ram_raddr;
    logic [PAD_W-1:0]          ram_rdata;
    t_pad                      rd_pad;

    // Keeper
    t_keep_ctl                       keep_ctl;
    logic [NEIGHBORS-1:0]            keep_valid;
    logic [NEIGHBORS-1:0]            keep_next_valid;
    logic [NEIGHBORS-1:0][IDX_W-1:0] keep_idx;

    logic                      in_xfer;
    logic                      out_free;
    logic [CMP_W-1:0]          q_ext;
    logic [NCNT_W-1:0]         found_sat;
    logic [REPORTED-1:0][NIDX_W-1:0] rep_idx;

    // Stage-one comparison signals
    logic [COORD_W:0]          s_dxp, s_dxn, s_dyp, s_dyn;
    logic                      s_xok, s_yok, s_hit;

    // Gap-stage differences
    logic [COORD_W:0]          g_dxp, g_dxn, g_dyp, g_dyn;

    assign rd_pad     = t_pad'(ram_rdata);
    assign out_free   = !r_ovalid || i_out_ready;
    assign o_in_ready = (r_state == ST_IDLE) && out_free;
    assign in_xfer    = i_in_valid && o_in_ready;
    assign q_ext      = CMP_W'(i_query_index);

    dnpc_ram #(
        .WIDTH (PAD_W),
        .DEPTH (PADS_MAX)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wpad),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign keep_ctl.clear  = (r_state == ST_QLAT);
    assign keep_ctl.insert = r_v3;

    dnpc_keep #(
        .NEIGHBORS (NEIGHBORS),
        .IDX_W     (IDX_W)
    ) u_keep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (keep_ctl),
        .i_dist  (r_d3),
        .i_idx   (r_p3),
        .o_valid (keep_valid),
        .o_idx   (keep_idx)
    );

    assign keep_next_valid = keep_valid >> 1;

    // Reported neighbor indices, zero where no neighbor stands
    for (genvar j = 0; j < REPORTED; j++) begin : g_rep
        if (j < NEIGHBORS) begin : g_kept
            logic [IDXO_W-1:0] wide;
            assign wide       = IDXO_W'(keep_idx[j]);
            assign rep_idx[j] = keep_valid[j] ? wide[NIDX_W-1:0] : '0;
        end else begin : g_none
            assign rep_idx[j] = '0;
        end
    end

    // Found count, saturated at the reported number
    always_comb begin
        logic [3:0] cnt;
        cnt = '0;
        for (int k = 0; k < NEIGHBORS; k++) begin
            cnt = cnt + 4'(keep_valid[k]);
        end
        found_sat = (cnt > 4'(REPORTED)) ? NCNT_W'(REPORTED) : cnt[NCNT_W-1:0];
    end

    // Stage one: direction test and magnitudes against the queried pad
    always_comb begin
        s_dxp = f_diff(rd_pad.x, r_ox);
        s_dxn = f_diff(r_ox, rd_pad.x);
        s_dyp = f_diff(rd_pad.y, r_oy);
        s_dyn = f_diff(r_oy, rd_pad.y);
        s_xok = r_quad[0] ? (!s_dxp[COORD_W] && (s_dxp != '0)) : s_dxp[COORD_W];
        s_yok = r_quad[1] ? (!s_dyp[COORD_W] && (s_dyp != '0)) : s_dyp[COORD_W];
        s_hit = r_v0 && s_xok && s_yok && (r_p0 != r_q);
    end

    // Distance pipeline: read, magnitude, square, sum
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v0 <= (r_state == ST_SCAN);
            r_v1 <= s_hit;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p0  <= r_scan[IDX_W-1:0];
        r_p1  <= r_p0;
        r_ax1 <= f_mag(s_dxp, s_dxn);
        r_ay1 <= f_mag(s_dyp, s_dyn);
        r_p2  <= r_p1;
        r_sx2 <= r_ax1 * r_ax1;
        r_sy2 <= r_ay1 * r_ay1;
        r_p3  <= r_p2;
        r_d3  <= {1'b0, r_sx2} + {1'b0, r_sy2};
    end

    // Gap unit operands
    always_comb begin
        g_dxp   = f_diff(rd_pad.x, r_ox);
        g_dxn   = f_diff(r_ox, rd_pad.x);
        g_dyp   = f_diff(rd_pad.y, r_oy);
        g_dyn   = f_diff(r_oy, rd_pad.y);
        gap_min = (r_gx < r_gy) ? r_gx : r_gy;
    end

    // Sequencer: next state, table port and result
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_q      = r_q;
        n_quad   = r_quad;
        n_ox     = r_ox;
        n_oy     = r_oy;
        n_ow     = r_ow;
        n_oh     = r_oh;
        n_scan   = r_scan;
        n_drain  = r_drain;
        n_k      = r_k;
        n_gax    = r_gax;
        n_gay    = r_gay;
        n_hw     = r_hw;
        n_hh     = r_hh;
        n_gx     = r_gx;
        n_gy     = r_gy;
        n_space  = r_space;
        n_ovalid = r_ovalid && !i_out_ready;
        n_status = r_status;
        n_ospace = r_ospace;
        n_ncount = r_ncount;
        n_n0     = r_n0;
        n_n1     = r_n1;
        n_n2     = r_n2;

        ram_we     = 1'b0;
        ram_waddr  = r_count[IDX_W-1:0];
        ram_wpad.x = i_pos_x;
        ram_wpad.y = i_pos_y;
        ram_wpad.w = i_box_width;
        ram_wpad.h = i_box_height;
        ram_raddr  = q_ext[IDX_W-1:0];

        case (r_state)
            ST_IDLE: begin
                if (in_xfer) begin
                    n_ovalid = 1'b1;
                    n_status = STATUS_OK;
                    n_ospace = '0;
                    n_ncount = '0;
                    n_n0     = '0;
                    n_n1     = '0;
                    n_n2     = '0;
                    case (t_kind'(i_kind))
                        KIND_LOAD: begin
                            if (r_count == CNT_W'(PADS_MAX)) begin
                                n_status = STATUS_FULL;
                            end else begin
                                ram_we  = 1'b1;
                                n_count = r_count + CNT_W'(1);
                            end
                        end
                        KIND_QUERY: begin
                            if (q_ext >= CMP_W'(r_count)) begin
                                n_status = STATUS_NOIDX;
                            end else begin
                                // table read of the queried pad is under way
                                n_ovalid = r_ovalid && !i_out_ready;
                                n_q      = q_ext[IDX_W-1:0];
                                n_quad   = i_quadrant;
                                n_state  = ST_QLAT;
                            end
                        end
                        KIND_CLEAR: begin
                            n_count = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_QLAT: begin
                n_ox    = rd_pad.x;
                n_oy    = rd_pad.y;
                n_ow    = rd_pad.w;
                n_oh    = rd_pad.h;
                n_scan  = '0;
                n_state = ST_SCAN;
            end
            ST_SCAN: begin
                // one pad read per cycle into the distance pipeline
                ram_raddr = r_scan[IDX_W-1:0];
                n_scan    = r_scan + CNT_W'(1);
                if (r_scan == r_count - CNT_W'(1)) begin
                    n_drain = '0;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_drain = r_drain + 2'd1;
                if (r_drain == 2'(SCAN_LAT - 1)) begin
                    n_k     = '0;
                    n_state = ST_GRD;
                end
            end
            ST_GRD: begin
                if (!keep_valid[0]) begin
                    n_space = $signed({3'b000, (r_ow > r_oh) ? r_ow : r_oh});
                    n_state = ST_FIN;
                end else begin
                    ram_raddr = keep_idx[r_k];
                    n_state   = ST_GABS;
                end
            end
            ST_GABS: begin
                n_gax   = f_mag(g_dxp, g_dxn);
                n_gay   = f_mag(g_dyp, g_dyn);
                n_hw    = {1'b0, r_ow[SIZE_W-1:1]} + {1'b0, rd_pad.w[SIZE_W-1:1]};
                n_hh    = {1'b0, r_oh[SIZE_W-1:1]} + {1'b0, rd_pad.h[SIZE_W-1:1]};
                n_state = ST_GDIF;
            end
            ST_GDIF: begin
                n_gx    = $signed({2'b00, r_gax}) - $signed({3'b000, r_hw});
                n_gy    = $signed({2'b00, r_gay}) - $signed({3'b000, r_hh});
                n_state = ST_GMIN;
            end
            ST_GMIN: begin
                if ((r_k == '0) || (gap_min < r_space)) begin
                    n_space = gap_min;
                end
                if (!keep_next_valid[r_k]) begin
                    n_state = ST_FIN;
                end else begin
                    n_k     = r_k + K_W'(1);
                    n_state = ST_GRD;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_status = STATUS_OK;
                    // zero floor and saturation of the clearance
                    if (r_space[GAP_W-1]) begin
                        n_ospace = '0;
                    end else if (r_space[GAP_W-2:SPACE_W] != '0) begin
                        n_ospace = SPACE_MAX;
                    end else begin
                        n_ospace = r_space[SPACE_W-1:0];
                    end
                    n_ncount = found_sat;
                    n_n0     = rep_idx[0];
                    n_n1     = rep_idx[1];
                    n_n2     = rep_idx[2];
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_q      <= n_q;
        r_quad   <= n_quad;
        r_ox     <= n_ox;
        r_oy     <= n_oy;
        r_ow     <= n_ow;
        r_oh     <= n_oh;
        r_scan   <= n_scan;
        r_drain  <= n_drain;
        r_k      <= n_k;
        r_gax    <= n_gax;
        r_gay    <= n_gay;
        r_hw     <= n_hw;
        r_hh     <= n_hh;
        r_gx     <= n_gx;
        r_gy     <= n_gy;
        r_space  <= n_space;
        r_status <= n_status;
        r_ospace <= n_ospace;
        r_ncount <= n_ncount;
        r_n0     <= n_n0;
        r_n1     <= n_n1;
        r_n2     <= n_n2;
    end

    assign o_out_valid       = r_ovalid;
    assign o_status          = r_status;
    assign o_available_space = r_ospace;
    assign o_neighbor_count  = r_ncount;
    assign o_first_neighbor  = r_n0;
    assign o_second_neighbor = r_n1;
    assign o_third_neighbor  = r_n2;

endmodule

// ===== tb/tb_directional_nearest_pad_clearance_core.sv =====
`timescale 1ns / 1ps

module tb_directional_nearest_pad_clearance_core;
    import dnpc_pkg::*;

    localparam int PADS_MAX     = PADS_MAX_DEF;
    localparam int NEIGHBORS    = NEIGHBORS_DEF;
    localparam int HOLD_CYCLES  = 250;
    localparam int SETTLE_CYCLES = 100;
    localparam int RUN_LIMIT_NS = 120_000_000;
    localparam int PHASE_ITEMS  = 125;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic [SIZE_W-1:0]         t_extent;

    localparam t_coord  COORD_MIN  = 32'sh8000_0000;
    localparam t_coord  COORD_MAX  = 32'sh7FFF_FFFF;
    localparam t_extent EXTENT_MAX = '1;
    localparam longint  CLEARANCE_CAP = 64'h7FFF_FFFF;

    // Kind code the block leaves alone
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // Quadrant codes: bit 0 selects +x, bit 1 selects +y
    localparam logic [QUAD_W-1:0] QUAD_UP_LEFT    = 2'd0;
    localparam logic [QUAD_W-1:0] QUAD_UP_RIGHT   = 2'd1;
    localparam logic [QUAD_W-1:0] QUAD_DOWN_LEFT  = 2'd2;
    localparam logic [QUAD_W-1:0] QUAD_DOWN_RIGHT = 2'd3;

    typedef struct {
        logic [KIND_W-1:0] kind;
        t_coord            pos_x;
        t_coord            pos_y;
        t_extent           box_width;
        t_extent           box_height;
        logic [QIDX_W-1:0] query_index;
        logic [QUAD_W-1:0] quadrant;
    } t_pad_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SPACE_W-1:0]  space;
        logic [NCNT_W-1:0]   count;
        logic [NIDX_W-1:0]   nb_first;
        logic [NIDX_W-1:0]   nb_second;
        logic [NIDX_W-1:0]   nb_third;
    } t_clearance_report;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_ready;
    logic [KIND_W-1:0]     i_kind;
    t_coord                i_pos_x;
    t_coord                i_pos_y;
    t_extent               i_box_width;
    t_extent               i_box_height;
    logic [QIDX_W-1:0]     i_query_index;
    logic [QUAD_W-1:0]     i_quadrant;
    logic                  o_out_valid;
    logic                  i_out_ready;
    logic [STATUS_W-1:0]   o_status;
    logic [SPACE_W-1:0]    o_available_space;
    logic [NCNT_W-1:0]     o_neighbor_count;
    logic [NIDX_W-1:0]     o_first_neighbor;
    logic [NIDX_W-1:0]     o_second_neighbor;
    logic [NIDX_W-1:0]     o_third_neighbor;

    // Shadow pad table
    t_coord  pad_x [PADS_MAX];
    t_coord  pad_y [PADS_MAX];
    t_extent pad_w [PADS_MAX];
    t_extent pad_h [PADS_MAX];
    int      pad_total = 0;

    t_clearance_report clearance_due [$];
    t_clearance_report seen_report;

    int mismatch_count = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit rx_hold_req    = 1'b0;
    int rx_hold_left   = 0;

    directional_nearest_pad_clearance_core #(
        .PADS_MAX  (PADS_MAX),
        .NEIGHBORS (NEIGHBORS)
    ) uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_kind            (i_kind),
        .i_pos_x           (i_pos_x),
        .i_pos_y           (i_pos_y),
        .i_box_width       (i_box_width),
        .i_box_height      (i_box_height),
        .i_query_index     (i_query_index),
        .i_quadrant        (i_quadrant),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_available_space (o_available_space),
        .o_neighbor_count  (o_neighbor_count),
        .o_first_neighbor  (o_first_neighbor),
        .o_second_neighbor (o_second_neighbor),
        .o_third_neighbor  (o_third_neighbor)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("FAIL");
        $finish;
    end

    // Apply one item to the shadow table and work out its report
    function automatic t_clearance_report apply_pad_item(t_pad_item it);
        t_clearance_report r;
        logic [65:0]       kept_dist [NEIGHBORS];
        int                kept_idx [NEIGHBORS];
        logic [65:0]       ax, ay, d;
        longint            ox, oy, dx, dy, gx, gy, gap, best, hq, hn;
        int                q, p, k, n, found, pos;
        r = '0;
        case (it.kind)
            KIND_LOAD: begin
                if (pad_total >= PADS_MAX) begin
                    r.status = STATUS_FULL;
                end else begin
                    pad_x[pad_total] = it.pos_x;
                    pad_y[pad_total] = it.pos_y;
                    pad_w[pad_total] = it.box_width;
                    pad_h[pad_total] = it.box_height;
                    pad_total++;
                end
            end
            KIND_CLEAR: pad_total = 0;
            KIND_QUERY: begin
                q = it.query_index;
                if (q >= pad_total) begin
                    r.status = STATUS_NOIDX;
                end else begin
                    ox = pad_x[q];
                    oy = pad_y[q];
                    found = 0;
                    // Keep the nearest pads strictly inside the quadrant; ties keep load order
                    for (p = 0; p < pad_total; p++) begin
                        dx = longint'(pad_x[p]) - ox;
                        dy = longint'(pad_y[p]) - oy;
                        if (p != q && (it.quadrant[0] ? dx > 0 : dx < 0)
                                   && (it.quadrant[1] ? dy > 0 : dy < 0)) begin
                            ax = (dx < 0) ? -dx : dx;
                            ay = (dy < 0) ? -dy : dy;
                            d = ax * ax + ay * ay;
                            pos = found;
                            while (pos > 0 && d < kept_dist[pos-1]) pos--;
                            if (pos < NEIGHBORS) begin
                                if (found < NEIGHBORS) found++;
                                for (k = found - 1; k > pos; k--) begin
                                    kept_idx[k]  = kept_idx[k-1];
                                    kept_dist[k] = kept_dist[k-1];
                                end
                                kept_idx[pos]  = p;
                                kept_dist[pos] = d;
                            end
                        end
                    end
                    // Least edge gap over the kept pads, halves rounded down
                    if (found == 0) begin
                        best = (pad_w[q] > pad_h[q]) ? pad_w[q] : pad_h[q];
                    end else begin
                        best = 0;
                        for (k = 0; k < found; k++) begin
                            n = kept_idx[k];
                            dx = longint'(pad_x[n]) - ox;
                            dy = longint'(pad_y[n]) - oy;
                            hq = pad_w[q] >> 1;
                            hn = pad_w[n] >> 1;
                            gx = ((dx < 0) ? -dx : dx) - (hq + hn);
                            hq = pad_h[q] >> 1;
                            hn = pad_h[n] >> 1;
                            gy = ((dy < 0) ? -dy : dy) - (hq + hn);
                            gap = (gx < gy) ? gx : gy;
                            if (k == 0 || gap < best) best = gap;
                        end
                    end
                    if (best < 0) best = 0;
                    if (best > CLEARANCE_CAP) best = CLEARANCE_CAP;
                    r.space = best[SPACE_W-1:0];
                    r.count = NCNT_W'((found > REPORTED) ? REPORTED : found);
                    if (found > 0) r.nb_first  = NIDX_W'(kept_idx[0]);
                    if (found > 1) r.nb_second = NIDX_W'(kept_idx[1]);
                    if (found > 2) r.nb_third  = NIDX_W'(kept_idx[2]);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic void check_field(string field, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatch_count++;
        end
    endfunction

    // Result checker: every transfer on the result channel against the oldest report due
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (clearance_due.size() == 0) begin
                $error("result transfer with no report due");
                mismatch_count++;
            end else begin
                seen_report = clearance_due.pop_front();
                check_field("status", seen_report.status, o_status);
                check_field("available_space", seen_report.space, o_available_space);
                check_field("neighbor_count", seen_report.count, o_neighbor_count);
                check_field("first_neighbor", seen_report.nb_first, o_first_neighbor);
                check_field("second_neighbor", seen_report.nb_second, o_second_neighbor);
                check_field("third_neighbor", seen_report.nb_third, o_third_neighbor);
            end
        end
    end

    // Result receiver: random stalls, plus a long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_left = HOLD_CYCLES;
                rx_hold_req  = 1'b0;
            end
            if (rx_hold_left > 0) begin
                i_out_ready = 1'b0;
                rx_hold_left--;
            end else begin
                i_out_ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // One input transfer; the report is predicted at the accepting edge
    task automatic send_item(t_pad_item it);
        t_clearance_report rep;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_kind        = it.kind;
        i_pos_x       = it.pos_x;
        i_pos_y       = it.pos_y;
        i_box_width   = it.box_width;
        i_box_height  = it.box_height;
        i_query_index = it.query_index;
        i_quadrant    = it.quadrant;
        i_in_valid    = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        rep = apply_pad_item(it);
        clearance_due = {clearance_due, rep};
    endtask

    // Unused fields carry random bits
    function automatic t_pad_item random_item(logic [KIND_W-1:0] kind);
        t_pad_item it;
        it.kind        = kind;
        it.pos_x       = t_coord'($urandom);
        it.pos_y       = t_coord'($urandom);
        it.box_width   = t_extent'($urandom);
        it.box_height  = t_extent'($urandom);
        it.query_index = QIDX_W'($urandom_range(1023));
        it.quadrant    = QUAD_W'($urandom_range(3));
        return it;
    endfunction

    task automatic load_pad(t_coord x, t_coord y, t_extent w, t_extent h);
        t_pad_item it;
        it = random_item(KIND_LOAD);
        it.pos_x      = x;
        it.pos_y      = y;
        it.box_width  = w;
        it.box_height = h;
        send_item(it);
    endtask

    task automatic query_pad(int idx, logic [QUAD_W-1:0] quad);
        t_pad_item it;
        it = random_item(KIND_QUERY);
        it.query_index = idx[QIDX_W-1:0];
        it.quadrant    = quad;
        send_item(it);
    endtask

    task automatic send_kind(logic [KIND_W-1:0] kind);
        send_item(random_item(kind));
    endtask

    // Drop valid, then wait for every report due
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (clearance_due.size() != 0) @(posedge i_clk);
    endtask

    // Coordinate styles: small grids (ties), coarse grid, full range, extremes, mixed
    function automatic t_coord rand_coord(int style);
        int s;
        int g;
        s = (style > 6) ? int'($urandom_range(6)) : style;
        g = int'($urandom_range(16)) - 8;
        case (s)
            0: return t_coord'(g);
            1: return t_coord'(g * 3);
            2: return t_coord'(g * 100);
            3: return t_coord'(g * (1 << 26));
            6: begin
                case ($urandom_range(3))
                    0: return COORD_MIN;
                    1: return COORD_MAX;
                    2: return t_coord'(0);
                    default: return t_coord'(-1);
                endcase
            end
            default: return t_coord'($urandom);
        endcase
    endfunction

    function automatic t_extent rand_extent(int style);
        int s;
        s = (style > 6) ? int'($urandom_range(6)) : style;
        case (s)
            2: return t_extent'($urandom_range(400));
            3: return t_extent'($urandom_range(1 << 27));
            4, 5: return t_extent'($urandom);
            6: begin
                case ($urandom_range(2))
                    0: return '0;
                    1: return EXTENT_MAX;
                    default: return t_extent'(1);
                endcase
            end
            default: return t_extent'($urandom_range(24));
        endcase
    endfunction

    // Empty table: query misses, clear and unused kind are harmless
    task automatic test_empty_table();
        send_kind(KIND_CLEAR);
        query_pad(0, QUAD_UP_LEFT);
        send_kind(KIND_UNUSED);
        wait_drained();
    endtask

    // Small hand-built layout: all quadrants, equal distances, overlap, on-axis pad,
    // more candidates than kept neighbors
    task automatic test_directed_geometry();
        load_pad(0, 0, 10, 20);
        load_pad(100, 100, 30, 4);
        load_pad(-100, 100, 0, 0);
        load_pad(100, -100, 7, 7);
        load_pad(-100, -100, 12, 3);
        load_pad(100, 100, 1, 1);       // same spot as pad 1, later load loses the tie
        load_pad(50, 50, 200, 200);     // overlaps the origin pad
        load_pad(300, 10, 2, 2);
        load_pad(0, 50, 5, 5);          // on the y axis of the origin pad
        query_pad(0, QUAD_UP_LEFT);
        query_pad(0, QUAD_UP_RIGHT);
        query_pad(0, QUAD_DOWN_LEFT);
        query_pad(0, QUAD_DOWN_RIGHT);
        query_pad(8, QUAD_DOWN_RIGHT);
        query_pad(7, QUAD_UP_LEFT);
        query_pad(9, QUAD_DOWN_RIGHT);  // one past the last loaded pad
        wait_drained();
    endtask

    // Corner coordinates: saturated clearance, widest pads, highest index
    task automatic test_extremes();
        send_kind(KIND_CLEAR);
        load_pad(COORD_MIN, COORD_MIN, '0, '0);
        load_pad(COORD_MAX, COORD_MAX, '0, '0);
        query_pad(0, QUAD_DOWN_RIGHT);
        query_pad(1, QUAD_UP_LEFT);
        load_pad(0, 0, EXTENT_MAX, EXTENT_MAX);
        query_pad(2, QUAD_UP_RIGHT);
        query_pad(1023, QUAD_DOWN_LEFT);
        wait_drained();
    endtask

    // Long receiver hold-off while loads and queries keep coming
    task automatic test_output_hold();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rx_hold_req    = 1'b1;
        send_kind(KIND_CLEAR);
        repeat (10) load_pad(rand_coord(1), rand_coord(1), rand_extent(1), rand_extent(1));
        repeat (3) query_pad($urandom_range(9), QUAD_W'($urandom_range(3)));
        wait_drained();
    endtask

    // Random scenes: mostly clear, a batch of loads in one style, then queries
    task automatic run_random_phase(int idle_pct, int stall_pct);
        int sent;
        int style;
        int loads;
        int queries;
        int pick;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < PHASE_ITEMS) begin
            if (pad_total > 150 || $urandom_range(99) < 75) begin
                send_kind(KIND_CLEAR);
                sent++;
            end
            style = $urandom_range(9);
            loads = ($urandom_range(9) == 0) ? $urandom_range(60, 25) : $urandom_range(20);
            repeat (loads) begin
                load_pad(rand_coord(style), rand_coord(style),
                         rand_extent(style), rand_extent(style));
                sent++;
            end
            queries = $urandom_range(10, 1);
            repeat (queries) begin
                pick = $urandom_range(99);
                if (pick < 5) begin
                    send_kind(KIND_UNUSED);
                end else if (pick < 20 || pad_total == 0) begin
                    query_pad($urandom_range(1023), QUAD_W'($urandom_range(3)));
                    sent++;
                end else begin
                    query_pad($urandom_range(pad_total - 1), QUAD_W'($urandom_range(3)));
                    sent++;
                end
            end
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_kind        = KIND_LOAD;
        i_pos_x       = '0;
        i_pos_y       = '0;
        i_box_width   = '0;
        i_box_height  = '0;
        i_query_index = '0;
        i_quadrant    = QUAD_UP_LEFT;
        repeat (5) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_empty_table();
        test_directed_geometry();
        test_extremes();
        test_output_hold();
        run_random_phase(0, 0);
        run_random_phase(63, 0);
        run_random_phase(0, 63);
        run_random_phase(35, 35);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
